### rtl/core/gaussian_elimination_solver_defines.svh
// Assertion macros shared by the solver RTL
`ifndef GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ges_pkg.sv
// Shared constants, types and helpers of the linear system solver
package ges_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int DEF_FRAC_BITS = 16;
    localparam int VALUE_W       = 32;
    localparam int ORDER_W       = 4;
    localparam int INDEX_W       = 3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PV_RD,
        ST_PV_CMP,
        ST_PV_END,
        ST_SW_A,
        ST_SW_B,
        ST_SW_C,
        ST_SW_D,
        ST_EL_RDN,
        ST_EL_DIV0,
        ST_EL_DIVW,
        ST_EL_RDJ,
        ST_EL_RDP,
        ST_EL_MUL,
        ST_EL_RND,
        ST_EL_WR,
        ST_BS_RDB,
        ST_BS_RDD,
        ST_BS_CHK,
        ST_BS_RD,
        ST_BS_MUL,
        ST_BS_RND,
        ST_BS_ACC,
        ST_BS_DIV0,
        ST_BS_DIVW,
        ST_OUT
    } state_t;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7fff_ffff;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] mag32(input logic signed [VALUE_W-1:0] v);
        return v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
    endfunction

endpackage

### rtl/core/ges_ram.sv
// Generic single-write, single-read RAM with registered read data
module ges_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/ges_div.sv
// Iterative fixed-point divider: one quotient bit per cycle, rounded and saturated
module ges_div #(
    parameter int FRAC_BITS = ges_pkg::DEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [ges_pkg::VALUE_W-1:0]   num,
    input  logic signed [ges_pkg::VALUE_W-1:0]   den,
    output logic                                 done,
    output logic signed [ges_pkg::VALUE_W-1:0]   quot
);

    localparam int VW = ges_pkg::VALUE_W;
    localparam int NW = VW + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] ud_reg, ud_next;
    logic          neg_reg, neg_next;
    logic signed [VW-1:0] res_reg, res_next;

    logic [VW:0]   sh;
    logic          ge;
    logic [VW-1:0] ud_in;
    logic [NW-1:0] un_in;

    always_comb begin
        ud_in    = ges_pkg::mag32(den);
        un_in    = NW'(ges_pkg::mag32(num)) << FRAC_BITS;
        sh       = {rem_reg, dvd_reg[NW-1]};
        ge       = sh >= {1'b0, ud_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        ud_next   = ud_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start) begin
            neg_next = num[VW-1] ^ den[VW-1];
            ud_next  = ud_in;
            dvd_next = un_in + NW'(ud_in >> 1);
            rem_next = '0;
            cnt_next = '0;
            if (ud_in == '0) begin
                res_next  = '0;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (cnt_reg == KW'(NW)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (|dvd_reg[NW-1:VW-1]) begin
                    res_next = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    res_next = neg_reg ? VW'(-dvd_reg[VW-1:0]) : VW'(dvd_reg[VW-1:0]);
                end
            end else begin
                rem_next = ge ? VW'(sh - {1'b0, ud_reg}) : sh[VW-1:0];
                dvd_next = {dvd_reg[NW-2:0], ge};
                cnt_next = cnt_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        ud_reg  <= ud_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule

### rtl/core/gaussian_elimination_solver.sv
// Solve: after the last element, about n^3/3 multiply-subtract steps, up to
// n(n-1)/2 + n divisions, pivot search, row swaps and back substitution steps run,
// then n result items are presented.
// Throughput: one item per cycle while loading; not ready during the solve or result output.
// The single RAM read port and the one bit-per-cycle divider set the solve time.
// Reset: synchronous active-low aresetn clears control state, order goes to 8.
`include "gaussian_elimination_solver_defines.svh"

module gaussian_elimination_solver #(
    parameter int MAX_ORDER = ges_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = ges_pkg::DEF_FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ges_pkg::VALUE_W-1:0]    s_matrix_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ges_pkg::VALUE_W-1:0]    m_solution_value,
    output logic [ges_pkg::INDEX_W-1:0]           m_solution_index,
    output logic                                  m_last_result,
    output logic                                  m_singular,
    input  logic                                  cfg_we,
    input  logic [ges_pkg::ORDER_W-1:0]           cfg_wdata
);

    localparam int VW      = ges_pkg::VALUE_W;
    localparam int ROW_LEN = MAX_ORDER + 1;
    localparam int DEPTH   = MAX_ORDER * ROW_LEN;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(MAX_ORDER + 2);
    localparam int IW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    ges_pkg::state_t state_reg, state_next;

    logic [ges_pkg::ORDER_W-1:0] order_reg, order_next;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] ld_r_reg, ld_r_next, ld_c_reg, ld_c_next;
    logic [CW-1:0] j_reg, j_next, i_reg, i_next, l_reg, l_next;
    logic [CW-1:0] p_reg, p_next, piv_reg, piv_next;
    logic [VW-1:0] best_reg, best_next;
    logic signed [VW-1:0] pv_reg, pv_next, tmp_reg, tmp_next;
    logic signed [VW-1:0] ajl_reg, ajl_next, apl_reg, apl_next;
    logic signed [VW-1:0] m_reg, m_next, diag_reg, diag_next;
    logic signed [63:0] prod_reg, prod_next, rnd_reg, rnd_next, acc_reg, acc_next;
    logic sing_reg, sing_next;

    logic signed [VW-1:0] sol_reg [MAX_ORDER];
    logic                 sol_we;
    logic [IW-1:0]        sol_wi;
    logic signed [VW-1:0] sol_wd;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_wdata, ram_rdata;
    logic signed [VW-1:0] rdata;

    logic                 div_start, div_done;
    logic signed [VW-1:0] div_num, div_den, div_quot;

    logic signed [VW-1:0] mul_a, mul_b;
    logic [VW-1:0]        rd_mag;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * ROW_LEN + int'(c));
    endfunction

    ges_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_matrix (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ges_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign rdata  = ram_rdata;
    assign rd_mag = ges_pkg::mag32(rdata);

    always_comb begin
        if (order_reg == '0) begin
            n_eff = CW'(1);
        end else if (int'(order_reg) > MAX_ORDER) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = CW'(order_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        order_next = order_reg;
        ld_r_next  = ld_r_reg;
        ld_c_next  = ld_c_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        l_next     = l_reg;
        p_next     = p_reg;
        piv_next   = piv_reg;
        best_next  = best_reg;
        pv_next    = pv_reg;
        tmp_next   = tmp_reg;
        ajl_next   = ajl_reg;
        apl_next   = apl_reg;
        m_next     = m_reg;
        diag_next  = diag_reg;
        prod_next  = prod_reg;
        rnd_next   = rnd_reg;
        acc_next   = acc_reg;
        sing_next  = sing_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_of(ld_r_reg, ld_c_reg);
        ram_wdata  = s_matrix_value;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        div_start  = 1'b0;
        div_num    = rdata;
        div_den    = pv_reg;
        sol_we     = 1'b0;
        sol_wi     = i_reg[IW-1:0];
        sol_wd     = '0;
        mul_a      = m_reg;
        mul_b      = ajl_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        unique case (state_reg)
            ges_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ram_we = 1'b1;
                    if (ld_c_reg == n_eff) begin
                        ld_c_next = '0;
                        if (ld_r_reg == n_eff - CW'(1)) begin
                            ld_r_next = '0;
                            sing_next = 1'b0;
                            if (n_eff == CW'(1)) begin
                                i_next     = '0;
                                state_next = ges_pkg::ST_BS_RDB;
                            end else begin
                                j_next     = '0;
                                i_next     = '0;
                                piv_next   = '0;
                                best_next  = '0;
                                state_next = ges_pkg::ST_PV_RD;
                            end
                        end else begin
                            ld_r_next = ld_r_reg + CW'(1);
                        end
                    end else begin
                        ld_c_next = ld_c_reg + CW'(1);
                    end
                end
            end
            ges_pkg::ST_PV_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(i_reg, j_reg);
                state_next = ges_pkg::ST_PV_CMP;
            end
            ges_pkg::ST_PV_CMP: begin
                if (rd_mag > best_reg) begin
                    best_next = rd_mag;
                    piv_next  = i_reg;
                    pv_next   = rdata;
                end
                if (i_reg == n_eff - CW'(1)) begin
                    state_next = ges_pkg::ST_PV_END;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = ges_pkg::ST_PV_RD;
                end
            end
            ges_pkg::ST_PV_END: begin
                if (best_reg == '0) begin
                    sing_next = 1'b1;
                    if (j_reg + CW'(2) >= n_eff) begin
                        i_next     = n_eff - CW'(1);
                        state_next = ges_pkg::ST_BS_RDB;
                    end else begin
                        j_next     = j_reg + CW'(1);
                        i_next     = j_reg + CW'(1);
                        piv_next   = j_reg + CW'(1);
                        best_next  = '0;
                        state_next = ges_pkg::ST_PV_RD;
                    end
                end else if (piv_reg != j_reg) begin
                    l_next     = j_reg;
                    state_next = ges_pkg::ST_SW_A;
                end else begin
                    p_next     = j_reg + CW'(1);
                    state_next = ges_pkg::ST_EL_RDN;
                end
            end
            ges_pkg::ST_SW_A: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(piv_reg, l_reg);
                state_next = ges_pkg::ST_SW_B;
            end
            ges_pkg::ST_SW_B: begin
                tmp_next   = rdata;
                ram_re     = 1'b1;
                ram_raddr  = addr_of(j_reg, l_reg);
                state_next = ges_pkg::ST_SW_C;
            end
            ges_pkg::ST_SW_C: begin
                ram_we     = 1'b1;
                ram_waddr  = addr_of(piv_reg, l_reg);
                ram_wdata  = rdata;
                state_next = ges_pkg::ST_SW_D;
            end
            ges_pkg::ST_SW_D: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(j_reg, l_reg);
                ram_wdata = tmp_reg;
                if (l_reg == n_eff) begin
                    p_next     = j_reg + CW'(1);
                    state_next = ges_pkg::ST_EL_RDN;
                end else begin
                    l_next     = l_reg + CW'(1);
                    state_next = ges_pkg::ST_SW_A;
                end
            end
            ges_pkg::ST_EL_RDN: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(p_reg, j_reg);
                state_next = ges_pkg::ST_EL_DIV0;
            end
            ges_pkg::ST_EL_DIV0: begin
                div_start  = 1'b1;
                state_next = ges_pkg::ST_EL_DIVW;
            end
            ges_pkg::ST_EL_DIVW: begin
                if (div_done) begin
                    m_next     = div_quot;
                    l_next     = j_reg + CW'(1);
                    state_next = ges_pkg::ST_EL_RDJ;
                end
            end
            ges_pkg::ST_EL_RDJ: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(j_reg, l_reg);
                state_next = ges_pkg::ST_EL_RDP;
            end
            ges_pkg::ST_EL_RDP: begin
                ajl_next   = rdata;
                ram_re     = 1'b1;
                ram_raddr  = addr_of(p_reg, l_reg);
                state_next = ges_pkg::ST_EL_MUL;
            end
            ges_pkg::ST_EL_MUL: begin
                apl_next   = rdata;
                prod_next  = 64'(mul_a) * 64'(mul_b);
                state_next = ges_pkg::ST_EL_RND;
            end
            ges_pkg::ST_EL_RND: begin
                rnd_next   = (prod_reg + HALF) >>> FRAC_BITS;
                state_next = ges_pkg::ST_EL_WR;
            end
            ges_pkg::ST_EL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(p_reg, l_reg);
                ram_wdata = ges_pkg::sat32(64'(apl_reg) - rnd_reg);
                if (l_reg == n_eff) begin
                    if (p_reg == n_eff - CW'(1)) begin
                        if (j_reg + CW'(2) >= n_eff) begin
                            i_next     = n_eff - CW'(1);
                            state_next = ges_pkg::ST_BS_RDB;
                        end else begin
                            j_next     = j_reg + CW'(1);
                            i_next     = j_reg + CW'(1);
                            piv_next   = j_reg + CW'(1);
                            best_next  = '0;
                            state_next = ges_pkg::ST_PV_RD;
                        end
                    end else begin
                        p_next     = p_reg + CW'(1);
                        state_next = ges_pkg::ST_EL_RDN;
                    end
                end else begin
                    l_next     = l_reg + CW'(1);
                    state_next = ges_pkg::ST_EL_RDJ;
                end
            end
            ges_pkg::ST_BS_RDB: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(i_reg, n_eff);
                state_next = ges_pkg::ST_BS_RDD;
            end
            ges_pkg::ST_BS_RDD: begin
                acc_next   = 64'(rdata);
                ram_re     = 1'b1;
                ram_raddr  = addr_of(i_reg, i_reg);
                state_next = ges_pkg::ST_BS_CHK;
            end
            ges_pkg::ST_BS_CHK: begin
                diag_next = rdata;
                if (rdata == '0) begin
                    sing_next = 1'b1;
                    sol_we    = 1'b1;
                    sol_wd    = '0;
                    if (i_reg == '0) begin
                        state_next = ges_pkg::ST_OUT;
                    end else begin
                        i_next     = i_reg - CW'(1);
                        state_next = ges_pkg::ST_BS_RDB;
                    end
                end else if (i_reg + CW'(1) == n_eff) begin
                    state_next = ges_pkg::ST_BS_DIV0;
                end else begin
                    l_next     = i_reg + CW'(1);
                    state_next = ges_pkg::ST_BS_RD;
                end
            end
            ges_pkg::ST_BS_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(i_reg, l_reg);
                state_next = ges_pkg::ST_BS_MUL;
            end
            ges_pkg::ST_BS_MUL: begin
                mul_a      = rdata;
                mul_b      = sol_reg[l_reg[IW-1:0]];
                prod_next  = 64'(mul_a) * 64'(mul_b);
                state_next = ges_pkg::ST_BS_RND;
            end
            ges_pkg::ST_BS_RND: begin
                rnd_next   = (prod_reg + HALF) >>> FRAC_BITS;
                state_next = ges_pkg::ST_BS_ACC;
            end
            ges_pkg::ST_BS_ACC: begin
                acc_next = acc_reg - rnd_reg;
                if (l_reg + CW'(1) == n_eff) begin
                    state_next = ges_pkg::ST_BS_DIV0;
                end else begin
                    l_next     = l_reg + CW'(1);
                    state_next = ges_pkg::ST_BS_RD;
                end
            end
            ges_pkg::ST_BS_DIV0: begin
                div_start  = 1'b1;
                div_num    = ges_pkg::sat32(acc_reg);
                div_den    = diag_reg;
                state_next = ges_pkg::ST_BS_DIVW;
            end
            ges_pkg::ST_BS_DIVW: begin
                if (div_done) begin
                    sol_we = 1'b1;
                    sol_wd = div_quot;
                    if (i_reg == '0) begin
                        state_next = ges_pkg::ST_OUT;
                    end else begin
                        i_next     = i_reg - CW'(1);
                        state_next = ges_pkg::ST_BS_RDB;
                    end
                end
            end
            ges_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (i_reg + CW'(1) == n_eff) begin
                        i_next     = '0;
                        state_next = ges_pkg::ST_LOAD;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            default: begin
                state_next = ges_pkg::ST_LOAD;
            end
        endcase

        if (cfg_we) begin
            order_next = cfg_wdata;
            ld_r_next  = '0;
            ld_c_next  = '0;
        end
    end

    assign m_solution_value = sing_reg ? '0 : sol_reg[i_reg[IW-1:0]];
    assign m_solution_index = ges_pkg::INDEX_W'(i_reg);
    assign m_last_result    = (i_reg + CW'(1) == n_eff);
    assign m_singular       = sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ges_pkg::ST_LOAD;
            order_reg <= ges_pkg::ORDER_RESET;
            ld_r_reg  <= '0;
            ld_c_reg  <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            l_reg     <= '0;
            p_reg     <= '0;
            piv_reg   <= '0;
            best_reg  <= '0;
            sing_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            order_reg <= order_next;
            ld_r_reg  <= ld_r_next;
            ld_c_reg  <= ld_c_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            l_reg     <= l_next;
            p_reg     <= p_next;
            piv_reg   <= piv_next;
            best_reg  <= best_next;
            sing_reg  <= sing_next;
        end
        pv_reg   <= pv_next;
        tmp_reg  <= tmp_next;
        ajl_reg  <= ajl_next;
        apl_reg  <= apl_next;
        m_reg    <= m_next;
        diag_reg <= diag_next;
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        acc_reg  <= acc_next;
        if (sol_we) begin
            sol_reg[sol_wi] <= sol_wd;
        end
    end

    `GES_ASSERT_IMP(a_no_overlap, s_ready, !m_valid, "input and result channels both open")
    `GES_ASSERT_IMP(a_singular_zero, m_valid && m_singular, m_solution_value == '0,
        "singular item carries a non-zero value")
    `GES_ASSERT_NXT(a_last_reload, m_valid && m_ready && m_last_result, s_ready,
        "block not ready after final item")
    `GES_ASSERT_NXT(a_cfg_restart, cfg_we, ld_r_reg == '0 && ld_c_reg == '0,
        "load position not cleared by order write")

endmodule

### tb/sv/solver_checker.sv
// Checker for the linear system solver: watches both channels, predicts solutions, compares
module solver_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [ges_pkg::VALUE_W-1:0]  s_matrix_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [ges_pkg::VALUE_W-1:0]  m_solution_value,
    input  logic [ges_pkg::INDEX_W-1:0]         m_solution_index,
    input  logic                                m_last_result,
    input  logic                                m_singular,
    input  logic                                cfg_we,
    input  logic [ges_pkg::ORDER_W-1:0]         cfg_wdata,
    output int                                  fail_count,
    output int                                  outstanding
);
    localparam int MAXN = ges_pkg::DEF_MAX_ORDER;
    localparam int ROWW = MAXN + 1;
    localparam int FB   = ges_pkg::DEF_FRAC_BITS;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         index;
        logic               last;
        logic               sing;
    } solution_t;

    logic signed [31:0]         coef [MAXN*ROWW];
    logic signed [31:0]         root [MAXN];
    logic [ges_pkg::ORDER_W-1:0] order_reg;
    int                         loaded;
    bit                         zero_pivot;
    solution_t                  solutions_due [$];

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] magnitude(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return w < 0 ? 32'(-w) : 32'(w);
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = a;
        wb = b;
        p = wa * wb + (64'sd1 <<< (FB - 1));
        return p >>> FB;
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] num,
                                                input logic signed [31:0] den);
        logic signed [63:0] nn;
        logic signed [63:0] dd;
        logic [63:0]        un;
        logic [63:0]        ud;
        logic [63:0]        q;
        bit                 neg;
        nn = num;
        nn = nn <<< FB;
        dd = den;
        neg = (nn < 0) != (dd < 0);
        un = nn < 0 ? 64'(-nn) : 64'(nn);
        ud = dd < 0 ? 64'(-dd) : 64'(dd);
        if (ud == 0) return 0;
        q = (un + ud / 2) / ud;
        if (neg) begin
            if (q >= 64'd2147483648) return 32'sh80000000;
            return 32'(-$signed(q));
        end
        if (q > 64'd2147483647) return 32'sh7fffffff;
        return q[31:0];
    endfunction

    function automatic int live_order();
        if (order_reg < 1) return 1;
        if (order_reg > MAXN) return MAXN;
        return order_reg;
    endfunction

    function automatic void eliminate(input int n);
        int                 piv;
        logic signed [31:0] t;
        logic signed [31:0] m;
        logic signed [63:0] acc;
        for (int j = 0; j + 1 < n; j++) begin
            piv = j;
            for (int i = j; i < n; i++)
                if (magnitude(coef[i*ROWW+j]) > magnitude(coef[piv*ROWW+j])) piv = i;
            if (coef[piv*ROWW+j] == 0) begin
                zero_pivot = 1;
                continue;
            end
            if (piv != j) begin
                for (int l = j; l <= n; l++) begin
                    t = coef[piv*ROWW+l];
                    coef[piv*ROWW+l] = coef[j*ROWW+l];
                    coef[j*ROWW+l] = t;
                end
            end
            for (int p = j + 1; p < n; p++) begin
                m = qdiv(coef[p*ROWW+j], coef[j*ROWW+j]);
                for (int l = j + 1; l <= n; l++)
                    coef[p*ROWW+l] = clip32(64'(coef[p*ROWW+l]) - qmul(m, coef[j*ROWW+l]));
                coef[p*ROWW+j] = 0;
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            acc = coef[i*ROWW+n];
            if (coef[i*ROWW+i] == 0) begin
                zero_pivot = 1;
                root[i] = 0;
                continue;
            end
            for (int j = i + 1; j < n; j++) acc -= qmul(coef[i*ROWW+j], root[j]);
            root[i] = qdiv(clip32(acc), coef[i*ROWW+i]);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        int        n;
        solution_t s;
        if (!aresetn) begin
            solutions_due.delete();
            loaded = 0;
            order_reg = ges_pkg::ORDER_RESET;
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                order_reg = cfg_wdata;
                loaded = 0;
            end
            if (s_valid && s_ready) begin
                n = live_order();
                if (loaded >= n * (n + 1)) loaded = 0;
                coef[(loaded / (n + 1)) * ROWW + loaded % (n + 1)] = s_matrix_value;
                loaded++;
                if (loaded == n * (n + 1)) begin
                    loaded = 0;
                    zero_pivot = 0;
                    eliminate(n);
                    for (int i = 0; i < n; i++) begin
                        s.value = zero_pivot ? 32'sd0 : root[i];
                        s.index = 3'(i);
                        s.last = (i + 1 == n);
                        s.sing = zero_pivot;
                        solutions_due.push_back(s);
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (solutions_due.size() == 0) begin
                    report_mismatch("unexpected result", m_solution_value, 0);
                end else begin
                    s = solutions_due.pop_front();
                    if (m_solution_value !== s.value)
                        report_mismatch("solution_value", m_solution_value, s.value);
                    if (m_solution_index !== s.index)
                        report_mismatch("solution_index", m_solution_index, s.index);
                    if (m_last_result !== s.last)
                        report_mismatch("last_result", m_last_result, s.last);
                    if (m_singular !== s.sing)
                        report_mismatch("singular", m_singular, s.sing);
                end
            end
        end
        outstanding <= solutions_due.size();
    end
endmodule

### tb/sv/testbench.sv
// Top of the solver testbench: clock, reset, stimulus and verdict
module testbench;
    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [ges_pkg::VALUE_W-1:0]  s_matrix_value;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [ges_pkg::VALUE_W-1:0]  m_solution_value;
    logic [ges_pkg::INDEX_W-1:0]         m_solution_index;
    logic                                m_last_result;
    logic                                m_singular;
    logic                                cfg_we;
    logic [ges_pkg::ORDER_W-1:0]         cfg_wdata;
    int                                  fail_count;
    int                                  outstanding;
    int                                  cycles = 0;
    int                                  items;
    int                                  systems;
    bit                                  steady;
    logic signed [31:0]                  cells [72];

    gaussian_elimination_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_matrix_value(s_matrix_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_solution_value(m_solution_value),
        .m_solution_index(m_solution_index), .m_last_result(m_last_result),
        .m_singular(m_singular), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    solver_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_matrix_value(s_matrix_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_solution_value(m_solution_value),
        .m_solution_index(m_solution_index), .m_last_result(m_last_result),
        .m_singular(m_singular), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 35);
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_value(input logic signed [31:0] v);
        bit taken;
        s_valid <= 1;
        s_matrix_value <= v;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        items++;
        if (!steady && $urandom_range(99) < 35) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        repeat (3) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_order(input int v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= 4'(v);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
        if (r < 70) return ($signed($urandom_range(0, 20)) - 10) <<< 16;
        if (r < 82) return $urandom;
        if (r < 92) return 0;
        case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 1;
            default: return -1;
        endcase
    endfunction

    task automatic send_system(input int n);
        int shape;
        shape = $urandom_range(9);
        for (int k = 0; k < n * (n + 1); k++) cells[k] = pick_value();
        if (shape == 0 && n > 1)
            for (int c = 0; c <= n; c++) cells[(n + 1) + c] = cells[c];
        if (shape == 1)
            for (int r = 0; r < n; r++) cells[r * (n + 1)] = 0;
        for (int k = 0; k < n * (n + 1); k++) push_value(cells[k]);
        systems++;
    endtask

    initial begin
        int plan [20] = '{8, 2, 3, 1, 4, 15, 5, 2, 3, 0, 6, 3, 2, 7, 4, 9, 2, 3, 5, 2};
        int n;
        aresetn = 0;
        s_valid = 0;
        s_matrix_value = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        steady = 0;
        items = 0;
        systems = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        write_order(1);
        push_value(32'sh7fffffff); push_value(32'sh80000000);
        push_value(32'sh80000000); push_value(32'sh7fffffff);
        push_value(0);             push_value(32'sh50000);
        push_value(1);             push_value(-1);
        push_value(-32'sh10000);   push_value(32'sh7fffffff);
        write_order(0);
        push_value(32'sh20000);    push_value(32'sh60000);
        write_order(2);
        push_value(32'sh30000); push_value(32'sh10000); push_value(-32'sh20000);
        write_order(3);
        push_value(0);          push_value(32'sh10000); push_value(0); push_value(32'sh30000);
        push_value(32'sh20000); push_value(0);          push_value(0); push_value(-32'sh40000);
        push_value(0);          push_value(0); push_value(32'sh40000); push_value(32'sh10000);

        for (int p = 0; items < 190; p++) begin
            write_order(plan[p % 20]);
            steady = (p == 3 || p == 12);
            n = plan[p % 20] < 1 ? 1 : (plan[p % 20] > 8 ? 8 : plan[p % 20]);
            repeat (n >= 6 ? 1 : $urandom_range(1, 3)) send_system(n);
        end
        steady = 0;
        drain();
        repeat (200) @(posedge aclk);
        $display("covered %0d matrix items in %0d systems, orders 0 to 15 incl. out of range",
                 items, systems);
        $display("singular, saturating and pivot-swap systems mixed in with random stalls");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
